@@ rtl/assert_macros.svh @@
// shared assertion macros, clocked and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every edge out of reset
`define FKX_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// same-cycle implication
`define FKX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define FKX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/fkx_pkg.sv @@
package fkx_pkg;

    // ip version codes
    localparam logic [3:0] VER4 = 4'd4;
    localparam logic [3:0] VER6 = 4'd6;

    // byte counter saturation point
    localparam logic [6:0] POS_LIMIT = 7'd64;

    // ipv4 header layout
    localparam logic [6:0] V4_MIN_HDR   = 7'd20;
    localparam logic [6:0] V4_PROTO_OFS = 7'd9;
    localparam logic [6:0] V4_SRC_OFS   = 7'd12;
    localparam logic [6:0] V4_DST_OFS   = 7'd16;
    localparam logic [3:0] V4_MIN_IHL   = 4'd5;

    // ipv6 header layout
    localparam logic [6:0] V6_HDR_LEN    = 7'd40;
    localparam logic [6:0] V6_PROTO_OFS  = 7'd6;
    localparam logic [6:0] V6_SRC_OFS    = 7'd8;
    localparam logic [6:0] V6_SRC_LO_OFS = 7'd16;
    localparam logic [6:0] V6_DST_OFS    = 7'd24;
    localparam logic [6:0] V6_DST_LO_OFS = 7'd32;

    // transport port field length in bytes
    localparam logic [6:0] PORT_BYTES = 7'd4;

    // transport protocols that carry ports
    localparam logic [7:0] PROTO_TCP     = 8'd6;
    localparam logic [7:0] PROTO_UDP     = 8'd17;
    localparam logic [7:0] PROTO_DCCP    = 8'd33;
    localparam logic [7:0] PROTO_SCTP    = 8'd132;
    localparam logic [7:0] PROTO_UDPLITE = 8'd136;

    typedef enum logic [1:0] {
        ST_V4  = 2'd0,
        ST_V6  = 2'd1,
        ST_ERR = 2'd2
    } t_status;

    // one packet byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_byte_item;

    // one flow key
    typedef struct packed {
        t_status     status;
        logic [7:0]  protocol;
        logic [63:0] src_addr_high;
        logic [63:0] src_addr_low;
        logic [63:0] dst_addr_high;
        logic [63:0] dst_addr_low;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } t_flow_key;

    // ipv4 header length in bytes, at least the minimum header
    function automatic logic [6:0] v4_hdr_len(input logic [3:0] ihl);
        logic [6:0] len;
        len = (ihl < V4_MIN_IHL) ? V4_MIN_HDR : {1'b0, ihl, 2'b00};
        return len;
    endfunction

    function automatic logic has_ports(input logic [7:0] proto);
        return (proto == PROTO_TCP) || (proto == PROTO_UDP) ||
               (proto == PROTO_DCCP) || (proto == PROTO_SCTP) ||
               (proto == PROTO_UDPLITE);
    endfunction

endpackage

@@ rtl/fkx_capture.sv @@
`include "assert_macros.svh"

module fkx_capture (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  fkx_pkg::t_byte_item i_item,
    output fkx_pkg::t_flow_key  o_key
);

    logic [6:0]  r_pos;
    logic [3:0]  r_ver;
    logic [3:0]  r_ihl;
    logic [7:0]  r_proto;
    logic [63:0] r_src_hi;
    logic [63:0] r_src_lo;
    logic [63:0] r_dst_hi;
    logic [63:0] r_dst_lo;
    logic [31:0] r_port;

    logic [6:0]  n_pos;
    logic [3:0]  n_ver;
    logic [3:0]  n_ihl;
    logic [7:0]  n_proto;
    logic [63:0] n_src_hi;
    logic [63:0] n_src_lo;
    logic [63:0] n_dst_hi;
    logic [63:0] n_dst_lo;
    logic [31:0] n_port;

    logic [7:0]  b;
    logic [6:0]  p;
    logic [6:0]  port_off;
    logic [6:0]  port_diff;
    logic        port_hit;
    logic        ok;

    assign b = i_item.data_byte;
    assign p = r_pos;

    // window of the four transport bytes
    assign port_off  = (r_ver == fkx_pkg::VER4) ? fkx_pkg::v4_hdr_len(r_ihl)
                                                : fkx_pkg::V6_HDR_LEN;
    assign port_diff = p - port_off;
    assign port_hit  = (p >= port_off) && (port_diff < fkx_pkg::PORT_BYTES) &&
                       ((r_ver == fkx_pkg::VER4) || (r_ver == fkx_pkg::VER6));

    // per-byte capture
    always_comb begin
        n_pos    = r_pos;
        n_ver    = r_ver;
        n_ihl    = r_ihl;
        n_proto  = r_proto;
        n_src_hi = r_src_hi;
        n_src_lo = r_src_lo;
        n_dst_hi = r_dst_hi;
        n_dst_lo = r_dst_lo;
        n_port   = r_port;
        if (i_step) begin
            if (p == 7'd0) begin
                n_ver    = b[7:4];
                n_ihl    = b[3:0];
                n_proto  = '0;
                n_src_hi = '0;
                n_src_lo = '0;
                n_dst_hi = '0;
                n_dst_lo = '0;
                n_port   = '0;
            end else if (p < fkx_pkg::POS_LIMIT) begin
                if (r_ver == fkx_pkg::VER4) begin
                    if (p == fkx_pkg::V4_PROTO_OFS) begin
                        n_proto = b;
                    end else if (p >= fkx_pkg::V4_SRC_OFS && p < fkx_pkg::V4_DST_OFS) begin
                        n_src_lo = {32'd0, r_src_lo[23:0], b};
                    end else if (p >= fkx_pkg::V4_DST_OFS && p < fkx_pkg::V4_MIN_HDR) begin
                        n_dst_lo = {32'd0, r_dst_lo[23:0], b};
                    end
                end else if (r_ver == fkx_pkg::VER6) begin
                    if (p == fkx_pkg::V6_PROTO_OFS) begin
                        n_proto = b;
                    end else if (p >= fkx_pkg::V6_SRC_OFS && p < fkx_pkg::V6_SRC_LO_OFS) begin
                        n_src_hi = {r_src_hi[55:0], b};
                    end else if (p >= fkx_pkg::V6_SRC_LO_OFS && p < fkx_pkg::V6_DST_OFS) begin
                        n_src_lo = {r_src_lo[55:0], b};
                    end else if (p >= fkx_pkg::V6_DST_OFS && p < fkx_pkg::V6_DST_LO_OFS) begin
                        n_dst_hi = {r_dst_hi[55:0], b};
                    end else if (p >= fkx_pkg::V6_DST_LO_OFS && p < fkx_pkg::V6_HDR_LEN) begin
                        n_dst_lo = {r_dst_lo[55:0], b};
                    end
                end
                // first transport byte lands in the top lane
                if (port_hit) begin
                    case (port_diff[1:0])
                        2'd0:    n_port[31:24] = b;
                        2'd1:    n_port[23:16] = b;
                        2'd2:    n_port[15:8]  = b;
                        2'd3:    n_port[7:0]   = b;
                        default: n_port        = r_port;
                    endcase
                end
            end
            n_pos = (p == fkx_pkg::POS_LIMIT) ? p : p + 7'd1;
        end
    end

    // header length check against bytes seen
    always_comb begin
        if (n_ver == fkx_pkg::VER4) begin
            ok = n_pos >= fkx_pkg::v4_hdr_len(n_ihl);
        end else if (n_ver == fkx_pkg::VER6) begin
            ok = n_pos >= fkx_pkg::V6_HDR_LEN;
        end else begin
            ok = 1'b0;
        end
    end

    // flow key of the packet ending with this byte
    always_comb begin
        o_key = '0;
        if (!ok) begin
            o_key.status = fkx_pkg::ST_ERR;
        end else begin
            o_key.status        = (n_ver == fkx_pkg::VER4) ? fkx_pkg::ST_V4 : fkx_pkg::ST_V6;
            o_key.protocol      = n_proto;
            o_key.src_addr_high = n_src_hi;
            o_key.src_addr_low  = n_src_lo;
            o_key.dst_addr_high = n_dst_hi;
            o_key.dst_addr_low  = n_dst_lo;
            if (fkx_pkg::has_ports(n_proto)) begin
                o_key.src_port = n_port[31:16];
                o_key.dst_port = n_port[15:0];
            end
        end
    end

    // byte counter, restarts after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_step && i_item.last_byte) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // capture registers, reloaded at the first byte of every packet
    always_ff @(posedge i_clk) begin
        r_ver    <= n_ver;
        r_ihl    <= n_ihl;
        r_proto  <= n_proto;
        r_src_hi <= n_src_hi;
        r_src_lo <= n_src_lo;
        r_dst_hi <= n_dst_hi;
        r_dst_lo <= n_dst_lo;
        r_port   <= n_port;
    end

    `FKX_ASSERT_ALWAYS(a_pos_range, i_clk, i_rst_n, r_pos <= fkx_pkg::POS_LIMIT)
    `FKX_ASSERT_NEXT(a_pos_restart, i_clk, i_rst_n, i_step && i_item.last_byte, r_pos == 7'd0)
    `FKX_ASSERT_NEXT(a_pos_hold, i_clk, i_rst_n, !i_step, $stable(r_pos))
    `FKX_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_key.status == fkx_pkg::ST_ERR, o_key.protocol == 8'd0 && o_key.src_port == 16'd0 && o_key.src_addr_low == 64'd0)

endmodule

@@ rtl/ip_header_flow_key_extractor_top.sv @@
// a flow key is loaded into the output register as its packet's last byte steps
// throughput: one byte per cycle unless stalled, sustained across packet boundaries
// the only stall is a last byte waiting while the output register holds an untaken key
// reset (synchronous, active low) empties the input and output registers and
// restarts the byte counter; capture registers reload at each packet's first byte
`include "assert_macros.svh"

module ip_header_flow_key_extractor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_protocol,
    output logic [63:0] o_src_addr_high,
    output logic [63:0] o_src_addr_low,
    output logic [63:0] o_dst_addr_high,
    output logic [63:0] o_dst_addr_low,
    output logic [15:0] o_src_port,
    output logic [15:0] o_dst_port
);

    logic                r_in_valid;
    fkx_pkg::t_byte_item r_in_item;
    logic                r_out_valid;
    fkx_pkg::t_flow_key  r_out_key;

    fkx_pkg::t_flow_key  key;
    logic                out_free;
    logic                step;
    logic                in_acc;

    // handshake control
    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && (!r_in_item.last_byte || out_free);
    assign o_in_ready = !r_in_valid || step;
    assign in_acc     = i_in_valid && o_in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_acc || (r_in_valid && !step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_item.data_byte <= i_data_byte;
            r_in_item.last_byte <= i_last_byte;
        end
    end

    fkx_capture u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in_item),
        .o_key   (key)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_item.last_byte) begin
            r_out_key <= key;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_key.status;
    assign o_protocol      = r_out_key.protocol;
    assign o_src_addr_high = r_out_key.src_addr_high;
    assign o_src_addr_low  = r_out_key.src_addr_low;
    assign o_dst_addr_high = r_out_key.dst_addr_high;
    assign o_dst_addr_low  = r_out_key.dst_addr_low;
    assign o_src_port      = r_out_key.src_port;
    assign o_dst_port      = r_out_key.dst_port;

    `FKX_ASSERT_IMP(a_mid_no_stall, i_clk, i_rst_n, r_in_valid && !r_in_item.last_byte, o_in_ready)
    `FKX_ASSERT_NEXT(a_key_loaded, i_clk, i_rst_n, step && r_in_item.last_byte, r_out_valid)
    `FKX_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_out_ready, !(step && r_in_item.last_byte))

endmodule
